// File: rtl/core/blockwise_bilinear_height_smoother_assert.svh
// Assertion macros shared by the height smoother modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef BLOCKWISE_BILINEAR_HEIGHT_SMOOTHER_ASSERT_SVH
`define BLOCKWISE_BILINEAR_HEIGHT_SMOOTHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBHS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbhs: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BBHS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbhs: next-cycle check failed");

`endif

// File: rtl/core/bbhs_pkg.sv
package bbhs_pkg;

  // Grid geometry.
  localparam int GRID_SIZE       = 16;
  localparam int BLOCK_SIZE      = 8;
  localparam int HEIGHT_BITS     = 10;
  localparam int POS_W           = 4;
  localparam int LIMIT_W         = POS_W + 1;
  localparam int BLOCKS_PER_SIDE = GRID_SIZE / BLOCK_SIZE;
  localparam int CORNER_COUNT    = BLOCKS_PER_SIDE * BLOCKS_PER_SIDE * 4;
  localparam int LIMIT           = BLOCKS_PER_SIDE * BLOCK_SIZE;
  localparam int SPAN            = BLOCK_SIZE - 1;
  localparam int OFF_W           = $clog2(BLOCK_SIZE);
  localparam int BLK_IDX_W       = $clog2(BLOCKS_PER_SIDE * BLOCKS_PER_SIDE);
  localparam int CORNER_AW       = BLK_IDX_W + 2;
  localparam int HEIGHT_MAX      = (1 << HEIGHT_BITS) - 1;

  // Rounded division by SPAN*SPAN through a reciprocal multiply.
  localparam int DEN       = SPAN * SPAN;
  localparam int HALF      = DEN / 2;
  localparam int SUM_W     = $clog2(DEN * HEIGHT_MAX + HALF + 1);
  localparam int DIV_SHIFT = SUM_W + $clog2(DEN);
  localparam int RECIP     = ((1 << DIV_SHIFT) + DEN - 1) / DEN;
  localparam int RECIP_W   = $clog2(RECIP + 1);

  // Shared multiply-accumulate operand widths.
  localparam int MA_W  = RECIP_W;
  localparam int MB_W  = SUM_W;
  localparam int ACC_W = MA_W + MB_W;
  localparam int QUO_W = ACC_W - DIV_SHIFT;

  // Action codes.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic                   action;
    logic [POS_W-1:0]       pos_x;
    logic [POS_W-1:0]       pos_z;
    logic [HEIGHT_BITS-1:0] height_in;
  } req_t;

  typedef struct packed {
    logic [HEIGHT_BITS-1:0] height_out;
    logic                   is_corner;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD00,
    ST_RD10,
    ST_RD01,
    ST_RD11,
    ST_HI1,
    ST_SUM0,
    ST_SUM1,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    CNR_00,
    CNR_10,
    CNR_01,
    CNR_11,
    CNR_OWN
  } cnr_sel_t;

  typedef enum logic [2:0] {
    A_SPAN_DX,
    A_DX,
    A_SPAN_DZ,
    A_DZ,
    A_RECIP
  } a_sel_t;

  typedef enum logic [1:0] {
    B_RDATA,
    B_ACC,
    B_LO
  } b_sel_t;

  typedef enum logic [1:0] {
    INIT_KEEP,
    INIT_ZERO,
    INIT_HALF
  } init_sel_t;

  typedef struct packed {
    logic      ready;
    logic      mac_en;
    init_sel_t init_sel;
    a_sel_t    a_sel;
    b_sel_t    b_sel;
    cnr_sel_t  cnr_sel;
    logic      lo_load;
    logic      res_load;
  } ctrl_t;

  typedef struct packed {
    logic query_go;
    logic go_inside;
    logic corner;
    logic slot_free;
  } seq_stat_t;

endpackage

// File: rtl/core/bbhs_ram.sv
module bbhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/bbhs_mac.sv
module bbhs_mac import bbhs_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  init_sel_t        init_sel,
  input  logic [MA_W-1:0]  a,
  input  logic [MB_W-1:0]  b,
  output logic [ACC_W-1:0] acc
);

  logic [ACC_W-1:0] base;
  logic [ACC_W-1:0] prod;

  // Starting value of the sum: keep running, restart at zero or at the rounding bias.
  always_comb begin
    unique case (init_sel)
      INIT_KEEP: base = acc;
      INIT_ZERO: base = '0;
      INIT_HALF: base = ACC_W'(HALF);
      default:   base = acc;
    endcase
  end

  assign prod = a * b;

  // The one multiplier of the block, followed by the accumulator register.
  always_ff @(posedge clk) begin
    if (en) begin
      acc <= base + prod;
    end
  end

endmodule

// File: rtl/core/bbhs_seq.sv
`include "blockwise_bilinear_height_smoother_assert.svh"

module bbhs_seq import bbhs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  seq_stat_t stat,
  output ctrl_t     ctrl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: four corner reads, three more accumulate steps, one divide step.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (stat.query_go) begin
          state_next = stat.go_inside ? ST_RD00 : ST_DONE;
        end
      end
      ST_RD00: state_next = stat.corner ? ST_DONE : ST_RD10;
      ST_RD10: state_next = ST_RD01;
      ST_RD01: state_next = ST_RD11;
      ST_RD11: state_next = ST_HI1;
      ST_HI1:  state_next = ST_SUM0;
      ST_SUM0: state_next = ST_SUM1;
      ST_SUM1: state_next = ST_DIV;
      ST_DIV:  state_next = ST_DONE;
      ST_DONE: begin
        if (stat.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs. Read data in each state belongs to the address of the state before.
  always_comb begin
    ctrl          = '0;
    ctrl.init_sel = INIT_KEEP;
    ctrl.a_sel    = A_DX;
    ctrl.b_sel    = B_RDATA;
    ctrl.cnr_sel  = CNR_OWN;
    unique case (state)
      ST_IDLE: begin
        ctrl.ready = 1'b1;
      end
      ST_RD00: begin
        ctrl.cnr_sel = stat.corner ? CNR_OWN : CNR_00;
      end
      ST_RD10: begin
        ctrl.cnr_sel  = CNR_10;
        ctrl.mac_en   = 1'b1;
        ctrl.init_sel = INIT_ZERO;
        ctrl.a_sel    = A_SPAN_DX;
      end
      ST_RD01: begin
        ctrl.cnr_sel = CNR_01;
        ctrl.mac_en  = 1'b1;
      end
      ST_RD11: begin
        ctrl.cnr_sel  = CNR_11;
        ctrl.mac_en   = 1'b1;
        ctrl.init_sel = INIT_ZERO;
        ctrl.a_sel    = A_SPAN_DX;
        ctrl.lo_load  = 1'b1;
      end
      ST_HI1: begin
        ctrl.mac_en = 1'b1;
      end
      ST_SUM0: begin
        ctrl.mac_en   = 1'b1;
        ctrl.init_sel = INIT_HALF;
        ctrl.a_sel    = A_DZ;
        ctrl.b_sel    = B_ACC;
      end
      ST_SUM1: begin
        ctrl.mac_en = 1'b1;
        ctrl.a_sel  = A_SPAN_DZ;
        ctrl.b_sel  = B_LO;
      end
      ST_DIV: begin
        ctrl.mac_en   = 1'b1;
        ctrl.init_sel = INIT_ZERO;
        ctrl.a_sel    = A_RECIP;
        ctrl.b_sel    = B_ACC;
      end
      ST_DONE: begin
        ctrl.res_load = stat.slot_free;
      end
      default: begin
        ctrl.ready = 1'b0;
      end
    endcase
  end

  // A finished result waits here until the output register can take it.
  `BBHS_ASSERT_NXT(a_done_holds, state == ST_DONE && !stat.slot_free, state == ST_DONE)

endmodule

// File: rtl/core/blockwise_bilinear_height_smoother.sv
// Loads: one transfer per cycle while the sequencer is idle, no result.
// Corner query: RD00, then DONE loads the output register. Interior query: four reads of
// the corner RAM feed the one multiply-accumulate unit (7 passes), then DONE likewise.
// Query outside the blocks: straight to DONE. No new item is taken until IDLE, and DONE
// waits while the output register is full. Reset clears the corner valid bits, so every
// corner reads as zero right after reset; no clearing pass is needed.
`include "blockwise_bilinear_height_smoother_assert.svh"

module blockwise_bilinear_height_smoother import bbhs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic                   req_fire;
  logic [OFF_W-1:0]       dx_d;
  logic [OFF_W-1:0]       dz_d;
  logic [BLK_IDX_W-1:0]   blk_d;
  logic                   inside_d;
  logic                   corner_d;
  logic                   wr_en;
  logic [CORNER_AW-1:0]   wr_addr;

  logic [OFF_W-1:0]       dx_q;
  logic [OFF_W-1:0]       dz_q;
  logic [BLK_IDX_W-1:0]   blk_q;
  logic                   cx_q;
  logic                   cz_q;
  logic                   inside_q;
  logic                   corner_q;

  logic [CORNER_COUNT-1:0] valid_bits;
  logic [CORNER_AW-1:0]    rd_addr;
  logic [HEIGHT_BITS-1:0]  rdata;
  logic                    rd_valid;
  logic [HEIGHT_BITS-1:0]  q_val;

  logic [MA_W-1:0]        mac_a;
  logic [MB_W-1:0]        mac_b;
  logic [ACC_W-1:0]       acc;
  logic [MB_W-1:0]        lo_q;
  logic [QUO_W-1:0]       quotient;
  logic [HEIGHT_BITS-1:0] result;

  ctrl_t     ctrl;
  seq_stat_t stat;
  logic      slot_free;

  assign req_ready = ctrl.ready;
  assign req_fire  = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;

  // Position decode: block index, offsets inside the block and the corner test.
  assign dx_d     = req.pos_x[OFF_W-1:0];
  assign dz_d     = req.pos_z[OFF_W-1:0];
  assign blk_d    = BLK_IDX_W'((int'(req.pos_x) / BLOCK_SIZE) * BLOCKS_PER_SIDE
                             + int'(req.pos_z) / BLOCK_SIZE);
  assign inside_d = ({1'b0, req.pos_x} < LIMIT_W'(LIMIT))
                 && ({1'b0, req.pos_z} < LIMIT_W'(LIMIT));
  assign corner_d = ((dx_d == '0) || (dx_d == OFF_W'(SPAN)))
                 && ((dz_d == '0) || (dz_d == OFF_W'(SPAN)));

  // Only a load onto a block corner is kept.
  assign wr_en   = req_fire && (req.action == ACT_LOAD) && inside_d && corner_d;
  assign wr_addr = {blk_d, dx_d != '0, dz_d != '0};

  // Hold the decoded query for the whole sequence.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      dx_q     <= dx_d;
      dz_q     <= dz_d;
      blk_q    <= blk_d;
      cx_q     <= dx_d != '0;
      cz_q     <= dz_d != '0;
      inside_q <= inside_d;
      corner_q <= inside_d && corner_d;
    end
  end

  // Corner valid bits: a corner never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (wr_en) begin
      valid_bits[wr_addr] <= 1'b1;
    end
  end

  // Corner read address for the current step.
  always_comb begin
    unique case (ctrl.cnr_sel)
      CNR_00:  rd_addr = {blk_q, 1'b0, 1'b0};
      CNR_10:  rd_addr = {blk_q, 1'b1, 1'b0};
      CNR_01:  rd_addr = {blk_q, 1'b0, 1'b1};
      CNR_11:  rd_addr = {blk_q, 1'b1, 1'b1};
      CNR_OWN: rd_addr = {blk_q, cx_q, cz_q};
      default: rd_addr = {blk_q, cx_q, cz_q};
    endcase
  end

  bbhs_ram #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (CORNER_COUNT)
  ) u_corner_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (req.height_in),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // The valid bit is registered alongside the RAM read.
  always_ff @(posedge clk) begin
    rd_valid <= valid_bits[rd_addr];
  end

  assign q_val = rd_valid ? rdata : '0;

  // Operand selection for the shared multiply-accumulate.
  always_comb begin
    unique case (ctrl.a_sel)
      A_SPAN_DX: mac_a = MA_W'(OFF_W'(SPAN) - dx_q);
      A_DX:      mac_a = MA_W'(dx_q);
      A_SPAN_DZ: mac_a = MA_W'(OFF_W'(SPAN) - dz_q);
      A_DZ:      mac_a = MA_W'(dz_q);
      A_RECIP:   mac_a = MA_W'(RECIP);
      default:   mac_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl.b_sel)
      B_RDATA: mac_b = MB_W'(q_val);
      B_ACC:   mac_b = acc[MB_W-1:0];
      B_LO:    mac_b = lo_q;
      default: mac_b = '0;
    endcase
  end

  bbhs_mac u_mac (
    .clk      (clk),
    .en       (ctrl.mac_en),
    .init_sel (ctrl.init_sel),
    .a        (mac_a),
    .b        (mac_b),
    .acc      (acc)
  );

  // The low-edge mix is parked while the high-edge mix is formed.
  always_ff @(posedge clk) begin
    if (ctrl.lo_load) begin
      lo_q <= acc[MB_W-1:0];
    end
  end

  assign stat.query_go  = req_fire && (req.action == ACT_QUERY);
  assign stat.go_inside = inside_d;
  assign stat.corner    = corner_q;
  assign stat.slot_free = slot_free;

  bbhs_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // Result selection: stored corner, rounded mix, or zero off the blocks.
  assign quotient = acc[ACC_W-1:DIV_SHIFT];

  always_comb begin
    if (!inside_q) begin
      result = '0;
    end else if (corner_q) begin
      result = q_val;
    end else begin
      result = quotient[HEIGHT_BITS-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_load) begin
      rsp.height_out <= result;
      rsp.is_corner  <= corner_q;
    end
  end

  `BBHS_ASSERT_NXT(a_load_marks_valid, wr_en, valid_bits[$past(wr_addr)])
  `BBHS_ASSERT_NXT(a_load_no_result, req_fire && req.action == ACT_LOAD, !$rose(rsp_valid))
  `BBHS_ASSERT_IMP(a_mix_in_range, ctrl.res_load && inside_q && !corner_q, quotient <= QUO_W'(HEIGHT_MAX))

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbhs_pkg::*;

  localparam int LONG_HOLD = 400;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS = 206;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Stimulus and prediction state.
  req_t items_to_send[$];
  rsp_t expected_heights[$];
  logic [HEIGHT_BITS-1:0] corner_store[CORNER_COUNT];
  logic req_taken = 1'b0;
  rsp_t oldest;
  int mismatches = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;

  blockwise_bilinear_height_smoother uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Index of one corner of one block in the corner store.
  function automatic int corner_slot(int bx, int bz, int cx, int cz);
    return (bx * BLOCKS_PER_SIDE + bz) * 4 + cx * 2 + cz;
  endfunction

  // A load only lands when it hits a block corner inside the blocks.
  function automatic void store_sample(req_t r);
    int dx, dz;
    dx = r.pos_x % BLOCK_SIZE;
    dz = r.pos_z % BLOCK_SIZE;
    if (r.pos_x < LIMIT && r.pos_z < LIMIT && (dx == 0 || dx == SPAN) &&
        (dz == 0 || dz == SPAN)) begin
      corner_store[corner_slot(r.pos_x / BLOCK_SIZE, r.pos_z / BLOCK_SIZE,
                               int'(dx != 0), int'(dz != 0))] = r.height_in;
    end
  endfunction

  // Smoothed height of a query: the stored value at a corner, otherwise the
  // bilinear mix of the block's corners, rounded half up.
  function automatic rsp_t smooth_height(req_t r);
    rsp_t res;
    int bx, bz, dx, dz;
    int unsigned q00, q01, q10, q11, lo, hi, total;
    res = '0;
    if (r.pos_x >= LIMIT || r.pos_z >= LIMIT) begin
      return res;
    end
    bx = r.pos_x / BLOCK_SIZE;
    bz = r.pos_z / BLOCK_SIZE;
    dx = r.pos_x % BLOCK_SIZE;
    dz = r.pos_z % BLOCK_SIZE;
    res.is_corner = (dx == 0 || dx == SPAN) && (dz == 0 || dz == SPAN);
    if (res.is_corner) begin
      res.height_out = corner_store[corner_slot(bx, bz, int'(dx != 0), int'(dz != 0))];
    end else begin
      q00 = 32'(corner_store[corner_slot(bx, bz, 0, 0)]);
      q01 = 32'(corner_store[corner_slot(bx, bz, 0, 1)]);
      q10 = 32'(corner_store[corner_slot(bx, bz, 1, 0)]);
      q11 = 32'(corner_store[corner_slot(bx, bz, 1, 1)]);
      lo = (SPAN - dx) * q00 + dx * q10;
      hi = (SPAN - dx) * q01 + dx * q11;
      total = (SPAN - dz) * lo + dz * hi;
      res.height_out = HEIGHT_BITS'((total + DEN / 2) / DEN);
    end
    return res;
  endfunction

  task automatic note_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  // Driver: a new item goes out once the previous one made its transfer.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (items_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        req_valid <= 1'b1;
        req <= items_to_send.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold whenever one is asked for.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left <= LONG_HOLD;
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Monitor: check each result transfer, then predict from each request transfer.
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
      foreach (corner_store[i]) corner_store[i] = '0;
    end else begin
      req_taken <= req_valid && req_ready;
      if (rsp_valid && rsp_ready) begin
        if (expected_heights.size() == 0) begin
          note_mismatch("unexpected result height_out", -1, int'(rsp.height_out));
        end else begin
          oldest = expected_heights.pop_front();
          if (rsp.height_out !== oldest.height_out) begin
            note_mismatch("height_out", int'(oldest.height_out), int'(rsp.height_out));
          end
          if (rsp.is_corner !== oldest.is_corner) begin
            note_mismatch("is_corner", int'(oldest.is_corner), int'(rsp.is_corner));
          end
        end
      end
      if (req_valid && req_ready) begin
        if (req.action == ACT_QUERY) begin
          expected_heights = {expected_heights, smooth_height(req)};
        end else begin
          store_sample(req);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_item(logic act, int x, int z, int h);
    req_t r;
    r.action = act;
    r.pos_x = POS_W'(x);
    r.pos_z = POS_W'(z);
    r.height_in = HEIGHT_BITS'(h);
    items_to_send = {items_to_send, r};
  endtask

  function automatic logic [HEIGHT_BITS-1:0] pick_height();
    case ($urandom_range(6))
      0: return '0;
      1: return HEIGHT_BITS'(HEIGHT_MAX);
      default: return HEIGHT_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] corner_coord();
    return POS_W'($urandom_range(BLOCKS_PER_SIDE - 1) * BLOCK_SIZE +
                  ($urandom_range(1) ? SPAN : 0));
  endfunction

  // Mostly corner loads and queries with random content, some noise.
  function automatic req_t random_item();
    req_t r;
    int pick;
    pick = $urandom_range(99);
    r.height_in = pick_height();
    r.pos_x = POS_W'($urandom);
    r.pos_z = POS_W'($urandom);
    if (pick < 35) begin
      r.action = ACT_LOAD;
      r.pos_x = corner_coord();
      r.pos_z = corner_coord();
    end else if (pick < 45) begin
      r.action = ACT_LOAD;
    end else if (pick < 62) begin
      r.action = ACT_QUERY;
      r.pos_x = corner_coord();
      r.pos_z = corner_coord();
    end else begin
      r.action = ACT_QUERY;
    end
    return r;
  endfunction

  // Wait until every item has made its transfer and every result has come back.
  task automatic settle();
    while (items_to_send.size() != 0 || req_valid || expected_heights.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int count, bit long_hold);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) items_to_send = {items_to_send, random_item()};
    if (long_hold) begin
      holds_asked++;
    end
    settle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: cleared store, maximum corners, ignored loads, block edges.
    add_item(ACT_QUERY, 0, 0, HEIGHT_MAX);
    add_item(ACT_QUERY, 3, 4, 0);
    add_item(ACT_LOAD, 0, 0, HEIGHT_MAX);
    add_item(ACT_LOAD, 0, 7, HEIGHT_MAX);
    add_item(ACT_LOAD, 7, 0, HEIGHT_MAX);
    add_item(ACT_LOAD, 7, 7, HEIGHT_MAX);
    add_item(ACT_QUERY, 3, 3, 0);
    add_item(ACT_QUERY, 7, 7, 0);
    add_item(ACT_LOAD, 3, 5, 555);
    add_item(ACT_QUERY, 3, 5, 0);
    add_item(ACT_LOAD, 0, 0, 0);
    add_item(ACT_QUERY, 1, 1, 0);
    add_item(ACT_QUERY, 6, 6, HEIGHT_MAX);
    add_item(ACT_QUERY, 0, 3, 0);
    add_item(ACT_LOAD, 8, 8, 1);
    add_item(ACT_LOAD, 8, 15, 2);
    add_item(ACT_LOAD, 15, 8, 1000);
    add_item(ACT_LOAD, 15, 15, HEIGHT_MAX);
    add_item(ACT_QUERY, 15, 15, 0);
    add_item(ACT_QUERY, 8, 15, 0);
    add_item(ACT_QUERY, 12, 9, 0);
    add_item(ACT_QUERY, 14, 1, 0);
    add_item(ACT_LOAD, 15, 0, 512);
    add_item(ACT_QUERY, 9, 3, 0);
    add_item(ACT_QUERY, 11, 15, 0);
    settle();

    // Random: free flow with a long receiver hold, then the idling mixes.
    run_phase(0, 0, PHASE_ITEMS, 1'b1);
    run_phase(77, 0, PHASE_ITEMS, 1'b0);
    run_phase(0, 77, PHASE_ITEMS, 1'b0);
    run_phase(26, 26, PHASE_ITEMS, 1'b0);

    repeat (20) @(posedge clk);
    if (expected_heights.size() != 0) begin
      note_mismatch("results still outstanding", 0, expected_heights.size());
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/bbhs_pkg.sv
rtl/core/bbhs_ram.sv
rtl/core/bbhs_mac.sv
rtl/core/bbhs_seq.sv
rtl/core/blockwise_bilinear_height_smoother.sv
tb/tb.sv
